// ----- src/efrxc_pkg.sv -----
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared types, constants and helper functions for the frame receiver.
// ----------------------------------------------------------------------------
package efrxc_pkg;

   localparam int MAX_FRAME   = 256;
   localparam int COUNT_W     = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [7:0] MARK_OPEN  = 8'h01;
   localparam logic [7:0] MARK_ESC   = 8'h02;
   localparam logic [7:0] MARK_CLOSE = 8'h03;
   localparam logic [7:0] ESC_MASK   = 8'h10;

   localparam logic [15:0] TYPE_PRIO_A = 16'h004d;
   localparam logic [15:0] TYPE_PRIO_B = 16'h8043;
   localparam logic [15:0] TYPE_PRIO_C = 16'h8045;
   localparam logic [15:0] TYPE_DROP_A = 16'h8011;
   localparam logic [15:0] TYPE_DROP_B = 16'h8012;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_CHECK    = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic [1:0] ROUTE_NORMAL   = 2'd0;
   localparam logic [1:0] ROUTE_PRIORITY = 2'd1;
   localparam logic [1:0] ROUTE_DROPPED  = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [15:0] msg_type;
      logic [15:0] payload_len;
      logic [8:0]  frame_len;
      logic [1:0]  status;
      logic [1:0]  route;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_OPEN,
      OP_CLOSE,
      OP_DATA
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [1:0] route_of(input logic [15:0] t);
      logic [1:0] r;
      r = ROUTE_NORMAL;
      if (t == TYPE_PRIO_A || t == TYPE_PRIO_B || t == TYPE_PRIO_C) begin
         r = ROUTE_PRIORITY;
      end else if (t == TYPE_DROP_A || t == TYPE_DROP_B) begin
         r = ROUTE_DROPPED;
      end
      return r;
   endfunction

endpackage

// ----- src/escaped_frame_receiver_xor_check.sv -----
// ----------------------------------------------------------------------------
// Escaped frame receiver with XOR checksum check
// Decodes escaped serial frames and reports each data byte and frame result.
//
//   Channel  Ports                            Beat
//   req      req_valid, req_stall, req_payload  one raw byte, chunk end flag
//   rsp      rsp_valid, rsp_stall, rsp_payload  one data byte or frame report
//
// One byte is accepted every cycle while the four-entry command queue has room.
// Each byte is registered in a queue entry, and its result in the back end result register.
// The front end reaches the back end only through the queue, so a stalled
// result fills the queue before req_stall rises.
// Synchronous reset clears the control state; queue entries and the result payload are not reset.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_xor_check import efrxc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   queue_status_type q_status;
   logic             push, pop;
   cmd_type          push_cmd, head_cmd;

   efrxc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   efrxc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   efrxc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- src/efrxc_front.sv -----
// ----------------------------------------------------------------------------
// Frame receiver front end
// Accepts raw bytes, removes escapes and classifies each beat as a command.
// ----------------------------------------------------------------------------
module efrxc_front import efrxc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   logic escape_ff, escape_in;
   logic in_frame_ff, in_frame_in;
   logic accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept;

   always_comb begin
      escape_in     = escape_ff;
      in_frame_in   = in_frame_ff;
      push_cmd.op   = OP_NONE;
      push_cmd.data = req_payload.rx_byte;
      push_cmd.last = req_payload.chunk_end;
      if (req_payload.rx_byte == MARK_OPEN) begin
         push_cmd.op = OP_OPEN;
         in_frame_in = 1'b1;
      end else if (req_payload.rx_byte == MARK_CLOSE) begin
         if (in_frame_ff) begin
            push_cmd.op = OP_CLOSE;
         end
         in_frame_in = 1'b0;
      end else if (req_payload.rx_byte == MARK_ESC) begin
         escape_in = 1'b1;
      end else begin
         escape_in = 1'b0;
         if (escape_ff) begin
            push_cmd.data = req_payload.rx_byte ^ ESC_MASK;
         end
         if (in_frame_ff) begin
            push_cmd.op = OP_DATA;
         end
      end
      if (req_payload.chunk_end) begin
         escape_in   = 1'b0;
         in_frame_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff   <= 1'b0;
         in_frame_ff <= 1'b0;
      end else if (accept) begin
         escape_ff   <= escape_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// ----- src/efrxc_queue.sv -----
// ----------------------------------------------------------------------------
// Frame receiver command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module efrxc_queue import efrxc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type q_status
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.empty = (count_ff == QCNT_W'(0));
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/efrxc_back.sv -----
// ----------------------------------------------------------------------------
// Frame receiver back end
// Tracks frame header and checksum state and drives the result register.
// ----------------------------------------------------------------------------
module efrxc_back import efrxc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  cmd_type          head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         xor_ff, xor_in;
   logic [15:0]        type_ff, type_in;
   logic [15:0]        length_ff, length_in;
   logic [7:0]         check_ff, check_in;
   logic               overflow_ff, overflow_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [16:0]        need_len;
   logic [15:0]        payload_pos;
   logic [1:0]         status;

   assign pop         = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign need_len    = 17'(length_ff) + 17'd5;
   assign payload_pos = 16'(count_ff) - 16'd5;

   always_comb begin
      if (count_ff < COUNT_W'(6)) begin
         status = STATUS_SHORT;
      end else if (overflow_ff || need_len > 17'(count_ff)) begin
         status = STATUS_OVERFLOW;
      end else if (check_ff != xor_ff) begin
         status = STATUS_CHECK;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      count_in     = count_ff;
      xor_in       = xor_ff;
      type_in      = type_ff;
      length_in    = length_ff;
      check_in     = check_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pop) begin
         unique case (head_cmd.op)
            OP_OPEN, OP_CLOSE: begin
               if (head_cmd.op == OP_CLOSE) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.kind        = KIND_REPORT;
                  rsp_in.data_byte   = '0;
                  rsp_in.byte_index  = '0;
                  rsp_in.msg_type    = type_ff;
                  rsp_in.payload_len = length_ff;
                  rsp_in.frame_len   = count_ff;
                  rsp_in.status      = status;
                  rsp_in.route       = route_of(type_ff);
               end
               count_in    = '0;
               xor_in      = '0;
               type_in     = '0;
               length_in   = '0;
               check_in    = '0;
               overflow_in = 1'b0;
            end
            OP_DATA: begin
               if (count_ff >= COUNT_W'(MAX_FRAME)) begin
                  overflow_in = 1'b1;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.kind        = KIND_DATA;
                  rsp_in.data_byte   = head_cmd.data;
                  rsp_in.byte_index  = count_ff[7:0];
                  count_in           = count_ff + COUNT_W'(1);
                  if (count_ff == COUNT_W'(0)) begin
                     type_in[15:8] = head_cmd.data;
                     xor_in        = xor_ff ^ head_cmd.data;
                  end else if (count_ff == COUNT_W'(1)) begin
                     type_in[7:0] = head_cmd.data;
                     xor_in       = xor_ff ^ head_cmd.data;
                  end else if (count_ff == COUNT_W'(2)) begin
                     length_in[15:8] = head_cmd.data;
                     xor_in          = xor_ff ^ head_cmd.data;
                  end else if (count_ff == COUNT_W'(3)) begin
                     length_in[7:0] = head_cmd.data;
                     xor_in         = xor_ff ^ head_cmd.data;
                  end else if (count_ff == COUNT_W'(4)) begin
                     check_in = head_cmd.data;
                  end else if (payload_pos < length_ff) begin
                     xor_in = xor_ff ^ head_cmd.data;
                  end
               end
            end
            default: begin
            end
         endcase
         if (head_cmd.last) begin
            count_in    = '0;
            xor_in      = '0;
            type_in     = '0;
            length_in   = '0;
            check_in    = '0;
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         xor_ff       <= '0;
         type_ff      <= '0;
         length_ff    <= '0;
         check_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         type_ff      <= type_in;
         length_ff    <= length_in;
         check_ff     <= check_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- src/efrxc_checker.sv -----
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module efrxc_checker import efrxc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result beat shown right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result beat changed.");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_DATA |->
         rsp_payload.msg_type == 16'd0 && rsp_payload.payload_len == 16'd0 &&
         rsp_payload.frame_len == 9'd0 && rsp_payload.status == STATUS_OK &&
         rsp_payload.route == ROUTE_NORMAL)
      else $error("Data beat carries report fields.");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_REPORT |->
         rsp_payload.data_byte == 8'd0 && rsp_payload.byte_index == 8'd0 &&
         rsp_payload.frame_len <= 9'(MAX_FRAME))
      else $error("Report beat carries data fields or a bad length.");

   a_short_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_REPORT &&
         rsp_payload.frame_len < 9'd6 |->
         rsp_payload.status == STATUS_SHORT)
      else $error("Short frame reported with a wrong status.");

endmodule

bind escaped_frame_receiver_xor_check efrxc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- test/escaped_frame_receiver_xor_check_checker.sv -----
// ----------------------------------------------------------------------------
// Escaped frame receiver checker
// Watches both channels of the frame receiver. It decodes every accepted
// input beat with its own copy of the parser state, queues the data bytes and
// frame reports that the beat should cause, and compares each accepted result
// beat field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_xor_check_checker import efrxc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      mismatch_count,
   output int      results_outstanding
);

   logic               in_frame;
   logic               escape_pending;
   logic               overflow_seen;
   logic [COUNT_W-1:0] byte_count;
   logic [7:0]         running_xor;
   logic [7:0]         received_check;
   logic [15:0]        type_word;
   logic [15:0]        length_word;
   rsp_type            expected_results[$];
   int                 failures = 0;

   task automatic clear_frame();
      byte_count     = '0;
      running_xor    = '0;
      type_word      = '0;
      length_word    = '0;
      received_check = '0;
      overflow_seen  = 1'b0;
   endtask

   task automatic decode_byte(input req_type beat);
      logic [7:0] d;
      rsp_type    res;
      int         pos;
      res = '0;
      if (beat.rx_byte == MARK_OPEN) begin
         clear_frame();
         in_frame = 1'b1;
      end else if (beat.rx_byte == MARK_CLOSE) begin
         if (in_frame) begin
            res.kind        = KIND_REPORT;
            res.msg_type    = type_word;
            res.payload_len = length_word;
            res.frame_len   = byte_count;
            if (int'(byte_count) < 6) begin
               res.status = STATUS_SHORT;
            end else if (overflow_seen || 5 + int'(length_word) > int'(byte_count)) begin
               res.status = STATUS_OVERFLOW;
            end else if (received_check != running_xor) begin
               res.status = STATUS_CHECK;
            end else begin
               res.status = STATUS_OK;
            end
            case (type_word)
               TYPE_PRIO_A, TYPE_PRIO_B, TYPE_PRIO_C: res.route = ROUTE_PRIORITY;
               TYPE_DROP_A, TYPE_DROP_B:              res.route = ROUTE_DROPPED;
               default:                               res.route = ROUTE_NORMAL;
            endcase
            expected_results.push_back(res);
            in_frame = 1'b0;
            clear_frame();
         end
      end else if (beat.rx_byte == MARK_ESC) begin
         escape_pending = 1'b1;
      end else begin
         d = escape_pending ? (beat.rx_byte ^ ESC_MASK) : beat.rx_byte;
         escape_pending = 1'b0;
         if (in_frame) begin
            if (int'(byte_count) >= MAX_FRAME) begin
               overflow_seen = 1'b1;
            end else begin
               pos = int'(byte_count);
               case (pos)
                  0:       type_word[15:8]   = d;
                  1:       type_word[7:0]    = d;
                  2:       length_word[15:8] = d;
                  3:       length_word[7:0]  = d;
                  4:       received_check    = d;
                  default: ;
               endcase
               if (pos < 4 || (pos >= 5 && pos - 5 < int'(length_word))) begin
                  running_xor = running_xor ^ d;
               end
               byte_count     = byte_count + COUNT_W'(1);
               res.kind       = KIND_DATA;
               res.data_byte  = d;
               res.byte_index = pos[7:0];
               expected_results.push_back(res);
            end
         end
      end
      if (beat.chunk_end) begin
         in_frame       = 1'b0;
         escape_pending = 1'b0;
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      string   diffs;
      if (reset) begin
         in_frame       = 1'b0;
         escape_pending = 1'b0;
         clear_frame();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: unexpected result beat: kind=%0d data=%02h idx=%0d",
                           $realtime, rsp_payload.kind, rsp_payload.data_byte,
                           rsp_payload.byte_index);
               end
            end else begin
               want  = expected_results.pop_front();
               diffs = "";
               if (rsp_payload.kind !== want.kind) diffs = {diffs, " kind"};
               if (rsp_payload.data_byte !== want.data_byte) diffs = {diffs, " data_byte"};
               if (rsp_payload.byte_index !== want.byte_index) diffs = {diffs, " byte_index"};
               if (rsp_payload.msg_type !== want.msg_type) diffs = {diffs, " msg_type"};
               if (rsp_payload.payload_len !== want.payload_len)
                  diffs = {diffs, " payload_len"};
               if (rsp_payload.frame_len !== want.frame_len) diffs = {diffs, " frame_len"};
               if (rsp_payload.status !== want.status) diffs = {diffs, " status"};
               if (rsp_payload.route !== want.route) diffs = {diffs, " route"};
               if (diffs != "") begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: mismatch in%s", $realtime, diffs);
                     $display("   expected kind=%0d data=%02h idx=%0d type=%04h",
                              want.kind, want.data_byte, want.byte_index, want.msg_type);
                     $display("            len=%04h flen=%0d st=%0d rt=%0d",
                              want.payload_len, want.frame_len, want.status, want.route);
                     $display("   actual   kind=%0d data=%02h idx=%0d type=%04h",
                              rsp_payload.kind, rsp_payload.data_byte,
                              rsp_payload.byte_index, rsp_payload.msg_type);
                     $display("            len=%04h flen=%0d st=%0d rt=%0d",
                              rsp_payload.payload_len, rsp_payload.frame_len,
                              rsp_payload.status, rsp_payload.route);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_payload);
         end
      end
      mismatch_count      <= failures;
      results_outstanding <= expected_results.size();
   end

endmodule

// ----- test/escaped_frame_receiver_xor_check_tb.sv -----
// ----------------------------------------------------------------------------
// Escaped frame receiver testbench
// Feeds the frame receiver a short directed sequence of marker and escape
// corner cases, then random frames with valid and broken checksums, cut
// headers, oversized bodies and line noise, under three idling mixes and
// one long result hold-off. A checker beside the block judges every result.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_xor_check_tb;
   import efrxc_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   int      mismatch_count;
   int      results_outstanding;
   int      items_sent;
   int      sender_gap_pct;
   int      receiver_gap_pct;
   logic    long_hold_request;

   escaped_frame_receiver_xor_check u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   escaped_frame_receiver_xor_check_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_payload         (req_payload),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload         (rsp_payload),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : receiver_side
      int hold_left;
      bit hold_taken;
      rsp_stall  = 1'b0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 300;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_gap_pct);
         end
      end
   end

   function automatic bit is_marker(input logic [7:0] b);
      return b == MARK_OPEN || b == MARK_ESC || b == MARK_CLOSE;
   endfunction

   task automatic send_raw(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_data(input logic [7:0] d);
      if (is_marker(d) || (!is_marker(d ^ ESC_MASK) && $urandom_range(0, 9) == 0)) begin
         send_raw(MARK_ESC, 1'b0);
         send_raw(d ^ ESC_MASK, 1'b0);
      end else begin
         send_raw(d, 1'b0);
      end
   endtask

   initial begin : stimulus
      int phase_end;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_payload       = '0;
      items_sent        = 0;
      sender_gap_pct    = 14;
      receiver_gap_pct  = 75;
      long_hold_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_raw(MARK_CLOSE, 1'b0);
      send_raw(8'h00, 1'b0);
      send_raw(8'hff, 1'b0);
      send_raw(MARK_ESC, 1'b0);
      send_raw(MARK_OPEN, 1'b0);
      send_raw(8'h41, 1'b0);
      send_raw(MARK_CLOSE, 1'b0);
      send_raw(MARK_OPEN, 1'b0);
      send_raw(8'h00, 1'b0);
      send_raw(8'h4d, 1'b0);
      send_raw(MARK_OPEN, 1'b0);
      send_raw(8'h80, 1'b0);
      send_raw(8'h11, 1'b0);
      send_raw(8'h00, 1'b0);
      send_raw(8'h00, 1'b0);
      send_raw(8'h91, 1'b0);
      send_raw(8'hff, 1'b0);
      send_raw(MARK_CLOSE, 1'b0);
      send_raw(MARK_OPEN, 1'b0);
      send_raw(MARK_ESC, 1'b0);
      send_raw(8'h13, 1'b0);
      send_raw(MARK_ESC, 1'b0);
      send_raw(MARK_CLOSE, 1'b1);
      send_raw(8'hee, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_gap_pct   = 14;
               receiver_gap_pct <= 75;
            end
            1: begin
               sender_gap_pct   = 75;
               receiver_gap_pct <= 14;
            end
            default: begin
               sender_gap_pct    = 0;
               receiver_gap_pct  <= 0;
               long_hold_request <= 1'b1;
            end
         endcase
         phase_end = items_sent + 500;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 82) begin : one_frame
               logic [15:0] kind_word;
               logic [15:0] len_word;
               logic [7:0]  header[5];
               logic [7:0]  body[$];
               logic [7:0]  sum;
               int          n_pay;
               int          n_hdr;
               case ($urandom_range(0, 9))
                  0:       kind_word = TYPE_PRIO_A;
                  1:       kind_word = TYPE_PRIO_B;
                  2:       kind_word = TYPE_PRIO_C;
                  3:       kind_word = TYPE_DROP_A;
                  4:       kind_word = TYPE_DROP_B;
                  default: kind_word = 16'($urandom);
               endcase
               if ($urandom_range(0, 9) == 0) begin
                  len_word = 16'($urandom);
                  n_pay    = $urandom_range(0, 16);
               end else begin
                  len_word = 16'($urandom_range(0, 12));
                  n_pay    = int'(len_word);
                  if ($urandom_range(0, 4) == 0) begin
                     n_pay += $urandom_range(1, 3);
                  end else if ($urandom_range(0, 9) == 0) begin
                     n_pay = $urandom_range(0, int'(len_word));
                  end
               end
               if ($urandom_range(0, 59) == 0) begin
                  n_pay = $urandom_range(MAX_FRAME - 8, MAX_FRAME + 6);
               end
               sum = kind_word[15:8] ^ kind_word[7:0] ^ len_word[15:8] ^ len_word[7:0];
               body.delete();
               for (int i = 0; i < n_pay; i++) begin
                  body.push_back(8'($urandom));
                  if (i < int'(len_word)) sum = sum ^ body[i];
               end
               if ($urandom_range(0, 6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
               header = '{kind_word[15:8], kind_word[7:0], len_word[15:8], len_word[7:0], sum};
               n_hdr  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 5;
               send_raw(MARK_OPEN, 1'b0);
               for (int i = 0; i < n_hdr; i++) send_data(header[i]);
               if (n_hdr == 5) begin
                  foreach (body[i]) send_data(body[i]);
               end
               if ($urandom_range(0, 19) != 0) begin
                  send_raw(MARK_CLOSE, $urandom_range(0, 9) == 0);
               end
            end else begin
               repeat ($urandom_range(1, 4)) send_raw(8'($urandom), $urandom_range(0, 9) == 0);
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
